/* sv/clcd_pkg.sv */
// Package: shared types and constants for the character LCD bus write engine.
package clcd_pkg;

   localparam int unsigned NUM_BITS   = 32;
   localparam int unsigned BCD_DIGITS = 10;
   localparam int unsigned BCD_WIDTH  = 4 * BCD_DIGITS;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] ROW_LIMIT    = 8'd4;
   localparam logic [7:0] COLUMN_LIMIT = 8'd80;

   localparam logic       FOUR_BIT_RESET = 1'b1;
   localparam logic [7:0] ROW1_RESET     = 8'd128;
   localparam logic [7:0] ROW2_RESET     = 8'd192;
   localparam logic [7:0] ROW3_RESET     = 8'd148;
   localparam logic [7:0] ROW4_RESET     = 8'd212;

   typedef enum logic [2:0] {
      OP_COMMAND     = 3'd0,
      OP_DATA        = 3'd1,
      OP_HIGH_NIBBLE = 3'd2,
      OP_SET_POS     = 3'd3,
      OP_NUMBER      = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      REG_FOUR_BIT = 3'd0,
      REG_ROW1     = 3'd1,
      REG_ROW2     = 3'd2,
      REG_ROW3     = 3'd3,
      REG_ROW4     = 3'd4
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_RAW,
      ST_BYTE
   } state_type;

endpackage

/* sv/char_lcd_bus_write_engine_top.sv */
// Top level: LCD request sequencer with a double-dabble conversion unit.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   operation, byte_value, row, column, number
//   rsp      out        rsp_valid/rsp_stall   register_select, bus_value, write_strobe,
//                                             status, last
//   csr      in         APB-style, 5-bit addr four_bit_mode, row1_base .. row4_base
//
// Command, data, high-nibble and set-position items go from idle straight to the output states.
// A number runs through the shift-add-3 unit over all 32 input bits, drops up to 9 leading
// zeros and loads the first character, then sends its characters one result at a time.
// Reset clears the sequencer, the output valid and loads the register reset values.
// req_stall stays high while an item is in work; rsp_stall holds the output register
// while it is valid, and the sequencer in its output states.
module char_lcd_bus_write_engine_top
   import clcd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_operation,
   input  logic [7:0]        req_byte_value,
   input  logic [7:0]        req_row,
   input  logic [7:0]        req_column,
   input  logic signed [31:0] req_number,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_register_select,
   output logic [7:0]        rsp_bus_value,
   output logic              rsp_write_strobe,
   output logic              rsp_status,
   output logic              rsp_last,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   state_type              state_ff, state_in;
   logic                   four_bit_ff;
   logic [7:0]             row1_ff, row2_ff, row3_ff, row4_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_rs_ff, rsp_rs_in;
   logic [7:0]             rsp_bus_ff, rsp_bus_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [7:0]             byte_ff, byte_in;
   logic                   rs_ff, rs_in;
   logic                   strobe_ff, strobe_in;
   logic                   status_ff, status_in;
   logic                   phase_ff, phase_in;
   logic                   neg_ff, neg_in;
   logic [NUM_BITS-1:0]    bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [4:0]             iter_ff, iter_in;
   logic [3:0]             dig_cnt_ff, dig_cnt_in;

   logic                   accept;
   logic                   out_free;
   logic                   emit;
   logic                   byte_done;
   logic                   reject;
   logic                   csr_write;
   logic [7:0]             row_base;
   logic [NUM_BITS-1:0]    num_bits;
   logic [NUM_BITS-1:0]    magnitude;
   logic [3:0]             top_digit;

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit       = out_free && (state_ff == ST_RAW || state_ff == ST_BYTE);
   assign byte_done  = !four_bit_ff || phase_ff;
   assign reject     = (req_row > ROW_LIMIT) || (req_column > COLUMN_LIMIT);
   assign num_bits   = req_number;
   assign magnitude  = num_bits[NUM_BITS-1] ? (~num_bits + 32'd1) : num_bits;
   assign top_digit  = bcd_ff[BCD_WIDTH-1 -: 4];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_register_select = rsp_rs_ff;
   assign rsp_bus_value       = rsp_bus_ff;
   assign rsp_write_strobe    = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_last            = rsp_last_ff;

   always_comb begin
      unique case (req_row[2:0])
         3'd1:    row_base = row1_ff;
         3'd2:    row_base = row2_ff;
         3'd3:    row_base = row3_ff;
         default: row_base = row4_ff;
      endcase
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_type'(csr_paddr[4:2]))
         REG_FOUR_BIT: csr_prdata = {31'd0, four_bit_ff};
         REG_ROW1:     csr_prdata = {24'd0, row1_ff};
         REG_ROW2:     csr_prdata = {24'd0, row2_ff};
         REG_ROW3:     csr_prdata = {24'd0, row3_ff};
         REG_ROW4:     csr_prdata = {24'd0, row4_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op_type'(req_operation))
                  OP_COMMAND, OP_DATA: state_in = ST_BYTE;
                  OP_HIGH_NIBBLE:      state_in = ST_RAW;
                  OP_SET_POS:          state_in = (reject || req_row == 8'd0) ? ST_RAW : ST_BYTE;
                  OP_NUMBER:           state_in = ST_CONVERT;
                  default:             state_in = ST_IDLE;
               endcase
            end
         end
         ST_CONVERT: begin
            if (iter_ff == 5'(NUM_BITS - 1)) state_in = ST_TRIM;
         end
         ST_TRIM: begin
            if (!(dig_cnt_ff > 4'd1 && top_digit == 4'd0)) state_in = ST_BYTE;
         end
         ST_RAW: begin
            if (emit) state_in = ST_IDLE;
         end
         ST_BYTE: begin
            if (emit && byte_done && dig_cnt_ff == 4'd0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [BCD_WIDTH-1:0] adj;
      byte_in    = byte_ff;
      rs_in      = rs_ff;
      strobe_in  = strobe_ff;
      status_in  = status_ff;
      phase_in   = phase_ff;
      neg_in     = neg_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      iter_in    = iter_ff;
      dig_cnt_in = dig_cnt_ff;
      adj        = bcd_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_rs_in     = rsp_rs_ff;
      rsp_bus_in    = rsp_bus_ff;
      rsp_strobe_in = rsp_strobe_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            phase_in   = 1'b0;
            dig_cnt_in = 4'd0;
            strobe_in  = 1'b1;
            status_in  = 1'b0;
            rs_in      = 1'b0;
            byte_in    = req_byte_value;
            case (op_type'(req_operation))
               OP_DATA:        rs_in = 1'b1;
               OP_HIGH_NIBBLE: byte_in = {4'd0, req_byte_value[7:4]};
               OP_SET_POS: begin
                  if (reject || req_row == 8'd0) begin
                     byte_in   = 8'd0;
                     strobe_in = 1'b0;
                     status_in = reject;
                  end else begin
                     byte_in = row_base + req_column + 8'hFF;
                  end
               end
               OP_NUMBER: begin
                  neg_in  = num_bits[NUM_BITS-1];
                  bin_in  = magnitude;
                  bcd_in  = '0;
                  iter_in = 5'd0;
               end
               default: rs_in = 1'b0;
            endcase
         end
         ST_CONVERT: begin
            for (int i = 0; i < BCD_DIGITS; i++) begin
               if (bcd_ff[4*i +: 4] >= 4'd5) adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
            end
            bcd_in     = {adj[BCD_WIDTH-2:0], bin_ff[NUM_BITS-1]};
            bin_in     = {bin_ff[NUM_BITS-2:0], 1'b0};
            iter_in    = iter_ff + 5'd1;
            dig_cnt_in = 4'(BCD_DIGITS);
         end
         ST_TRIM: begin
            rs_in    = 1'b1;
            phase_in = 1'b0;
            if (dig_cnt_ff > 4'd1 && top_digit == 4'd0) begin
               bcd_in     = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
               dig_cnt_in = dig_cnt_ff - 4'd1;
            end else if (neg_ff) begin
               byte_in = CHAR_MINUS;
            end else begin
               byte_in    = CHAR_ZERO | {4'd0, top_digit};
               bcd_in     = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
               dig_cnt_in = dig_cnt_ff - 4'd1;
            end
         end
         ST_RAW: begin
            if (emit) begin
               rsp_valid_in  = 1'b1;
               rsp_rs_in     = 1'b0;
               rsp_bus_in    = byte_ff;
               rsp_strobe_in = strobe_ff;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
            end
         end
         ST_BYTE: begin
            if (emit) begin
               rsp_valid_in  = 1'b1;
               rsp_rs_in     = rs_ff;
               rsp_strobe_in = 1'b1;
               rsp_status_in = 1'b0;
               if (!byte_done) begin
                  rsp_bus_in  = {4'd0, byte_ff[7:4]};
                  rsp_last_in = 1'b0;
                  phase_in    = 1'b1;
               end else begin
                  rsp_bus_in  = four_bit_ff ? {4'd0, byte_ff[3:0]} : byte_ff;
                  rsp_last_in = (dig_cnt_ff == 4'd0);
                  phase_in    = 1'b0;
                  if (dig_cnt_ff != 4'd0) begin
                     byte_in    = CHAR_ZERO | {4'd0, top_digit};
                     bcd_in     = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
                     dig_cnt_in = dig_cnt_ff - 4'd1;
                  end
               end
            end
         end
         default: rsp_valid_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         four_bit_ff  <= FOUR_BIT_RESET;
         row1_ff      <= ROW1_RESET;
         row2_ff      <= ROW2_RESET;
         row3_ff      <= ROW3_RESET;
         row4_ff      <= ROW4_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (reg_type'(csr_paddr[4:2]))
               REG_FOUR_BIT: four_bit_ff <= csr_pwdata[0];
               REG_ROW1:     row1_ff     <= csr_pwdata[7:0];
               REG_ROW2:     row2_ff     <= csr_pwdata[7:0];
               REG_ROW3:     row3_ff     <= csr_pwdata[7:0];
               REG_ROW4:     row4_ff     <= csr_pwdata[7:0];
               default:      four_bit_ff <= four_bit_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_rs_ff     <= rsp_rs_in;
      rsp_bus_ff    <= rsp_bus_in;
      rsp_strobe_ff <= rsp_strobe_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      byte_ff       <= byte_in;
      rs_ff         <= rs_in;
      strobe_ff     <= strobe_in;
      status_ff     <= status_in;
      phase_ff      <= phase_in;
      neg_ff        <= neg_in;
      bin_ff        <= bin_in;
      bcd_ff        <= bcd_in;
      iter_ff       <= iter_in;
      dig_cnt_ff    <= dig_cnt_in;
   end

`ifndef SYNTHESIS
   a_number_starts_convert: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_NUMBER) |=> (state_ff == ST_CONVERT))
      else $error("number item did not start conversion");

   a_trim_digit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRIM) |-> (dig_cnt_ff >= 4'd1 && dig_cnt_ff <= 4'(BCD_DIGITS)))
      else $error("digit count out of range while trimming");

   a_nibble_upper_zero: assert property (@(posedge clock) disable iff (reset)
      (four_bit_ff && rsp_valid_ff) |-> (rsp_bus_ff[7:4] == 4'd0))
      else $error("upper bus bits set in nibble mode");
`endif

endmodule

/* test/char_lcd_bus_write_engine_top_test.sv */
// Testbench for the LCD bus write engine: directed and random requests against a predictor.
module char_lcd_bus_write_engine_top_test
   import clcd_pkg::*;
;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 60;
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic       register_select;
      logic [7:0] bus_value;
      logic       write_strobe;
      logic       status;
      logic       last;
   } lcd_write_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_operation = '0;
   logic [7:0]         req_byte_value = '0;
   logic [7:0]         req_row = '0;
   logic [7:0]         req_column = '0;
   logic signed [31:0] req_number = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_register_select;
   logic [7:0]         rsp_bus_value;
   logic               rsp_write_strobe;
   logic               rsp_status;
   logic               rsp_last;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [4:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   logic          four_bit_mode;
   logic [7:0]    row_base [1:4];
   lcd_write_type bus_writes [$];

   int req_idle_pct   = 0;
   int rsp_idle_pct   = 0;
   int failures       = 0;
   int requests_sent  = 0;
   int ignored_sent   = 0;
   int writes_checked = 0;
   int settings_used  = 1;
   int quiet_cycles   = 0;

   always #4 clock = ~clock;

   char_lcd_bus_write_engine_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_byte_value(req_byte_value),
      .req_row(req_row),
      .req_column(req_column),
      .req_number(req_number),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_register_select(rsp_register_select),
      .rsp_bus_value(rsp_bus_value),
      .rsp_write_strobe(rsp_write_strobe),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   function automatic void push_write(logic rs, logic [7:0] bus, logic strobe, logic status);
      lcd_write_type w;
      w = '{rs, bus, strobe, status, 1'b0};
      bus_writes.push_back(w);
   endfunction

   function automatic void push_byte(logic rs, logic [7:0] b);
      if (four_bit_mode) begin
         push_write(rs, {4'h0, b[7:4]}, 1'b1, 1'b0);
         push_write(rs, {4'h0, b[3:0]}, 1'b1, 1'b0);
      end else begin
         push_write(rs, b, 1'b1, 1'b0);
      end
   endfunction

   function automatic void predict_writes(logic [2:0] op, logic [7:0] b, logic [7:0] row,
                                          logic [7:0] col, logic [31:0] num);
      int          first;
      int          n;
      logic [7:0]  address;
      logic [31:0] mag;
      logic [7:0]  digits [10];
      first = bus_writes.size();
      n = 0;
      case (op)
         OP_COMMAND:     push_byte(1'b0, b);
         OP_DATA:        push_byte(1'b1, b);
         OP_HIGH_NIBBLE: push_write(1'b0, {4'h0, b[7:4]}, 1'b1, 1'b0);
         OP_SET_POS: begin
            if (row > ROW_LIMIT || col > COLUMN_LIMIT) begin
               push_write(1'b0, 8'h00, 1'b0, 1'b1);
            end else if (row == 8'd0) begin
               push_write(1'b0, 8'h00, 1'b0, 1'b0);
            end else begin
               address = row_base[row[2:0]] + col - 8'd1;
               push_byte(1'b0, address);
            end
         end
         OP_NUMBER: begin
            mag = num[31] ? 32'd0 - num : num;
            do begin
               digits[n] = CHAR_ZERO + 8'(mag % 32'd10);
               n++;
               mag = mag / 32'd10;
            end while (mag != 32'd0);
            if (num[31])
               push_byte(1'b1, CHAR_MINUS);
            while (n > 0) begin
               n--;
               push_byte(1'b1, digits[n]);
            end
         end
         default: ;
      endcase
      if (bus_writes.size() > first)
         bus_writes[bus_writes.size() - 1].last = 1'b1;
   endfunction

   task automatic send_request(logic [2:0] op, logic [7:0] b, logic [7:0] row,
                               logic [7:0] col, logic [31:0] num);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_byte_value <= b;
      req_row        <= row;
      req_column     <= col;
      req_number     <= num;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_writes(op, b, row, col, num);
      if (op <= OP_NUMBER)
         requests_sent++;
      else
         ignored_sent++;
   endtask

   // drop valid, drain all results, then cover items that produce none
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bus_writes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(reg_type index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (index)
         REG_FOUR_BIT: four_bit_mode = value[0];
         REG_ROW1:     row_base[1] = value[7:0];
         REG_ROW2:     row_base[2] = value[7:0];
         REG_ROW3:     row_base[3] = value[7:0];
         REG_ROW4:     row_base[4] = value[7:0];
         default: ;
      endcase
      settings_used++;
   endtask

   task automatic write_settings(logic mode, logic [31:0] b1, logic [31:0] b2,
                                 logic [31:0] b3, logic [31:0] b4);
      write_register(REG_FOUR_BIT, {31'd0, mode});
      write_register(REG_ROW1, b1);
      write_register(REG_ROW2, b2);
      write_register(REG_ROW3, b3);
      write_register(REG_ROW4, b4);
   endtask

   task automatic send_random_request();
      int          pick;
      logic [2:0]  op;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [31:0] num;
      pick = $urandom_range(99);
      if (pick < 15)
         op = OP_COMMAND;
      else if (pick < 30)
         op = OP_DATA;
      else if (pick < 40)
         op = OP_HIGH_NIBBLE;
      else if (pick < 65)
         op = OP_SET_POS;
      else if (pick < 95)
         op = OP_NUMBER;
      else
         op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      row = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(5));
      col = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(82));
      case ($urandom_range(3))
         0: num = $urandom;
         1: num = $urandom_range(99999);
         2: num = 32'd0 - 32'($urandom_range(99999));
         default: num = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(9)
                                          : 32'h7FFF_FFFF - $urandom_range(9);
      endcase
      send_request(op, 8'($urandom), row, col, num);
   endtask

   task automatic test_basic_requests();
      send_request(OP_COMMAND, 8'h00, 8'd0, 8'd0, 32'd0);
      send_request(OP_COMMAND, 8'hFF, 8'd0, 8'd0, 32'd0);
      send_request(OP_DATA, 8'h41, 8'd0, 8'd0, 32'd0);
      send_request(OP_DATA, 8'h80, 8'd0, 8'd0, 32'd0);
      send_request(OP_HIGH_NIBBLE, 8'hF7, 8'd0, 8'd0, 32'd0);
      send_request(OP_HIGH_NIBBLE, 8'h08, 8'd0, 8'd0, 32'd0);
      send_request(OP_SET_POS, 8'h00, 8'd1, 8'd1, 32'd0);
      send_request(OP_SET_POS, 8'h00, 8'd2, 8'd80, 32'd0);
      send_request(OP_SET_POS, 8'h00, 8'd3, 8'd0, 32'd0);
      send_request(OP_SET_POS, 8'h00, 8'd4, 8'd40, 32'd0);
      send_request(OP_SET_POS, 8'h00, 8'd0, 8'd7, 32'd0);
      send_request(OP_SET_POS, 8'h00, 8'd5, 8'd1, 32'd0);
      send_request(OP_SET_POS, 8'h00, 8'd1, 8'd81, 32'd0);
      send_request(OP_SET_POS, 8'h00, 8'd255, 8'd255, 32'd0);
      send_request(OP_NUMBER, 8'h00, 8'd0, 8'd0, 32'd0);
      send_request(OP_NUMBER, 8'h00, 8'd0, 8'd0, 32'hFFFF_FFFF);
      send_request(OP_NUMBER, 8'h00, 8'd0, 8'd0, 32'd7);
      send_request(OP_NUMBER, 8'h00, 8'd0, 8'd0, 32'h7FFF_FFFF);
      send_request(OP_NUMBER, 8'h00, 8'd0, 8'd0, 32'h8000_0000);
      send_request(OP_NUMBER, 8'h00, 8'd0, 8'd0, 32'd1000000000);
      for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
         send_request(3'(op), 8'hFF, 8'd1, 8'd1, 32'hFFFF_FFFF);
      settle();
   endtask

   task automatic test_register_extremes();
      write_settings(1'b0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd255);
      send_request(OP_SET_POS, 8'h00, 8'd1, 8'd0, 32'd0);
      send_request(OP_SET_POS, 8'h00, 8'd2, 8'd80, 32'd0);
      send_request(OP_SET_POS, 8'h00, 8'd3, 8'd1, 32'd0);
      send_request(OP_SET_POS, 8'h00, 8'd4, 8'd0, 32'd0);
      send_request(OP_COMMAND, 8'hA5, 8'd0, 8'd0, 32'd0);
      send_request(OP_HIGH_NIBBLE, 8'hC3, 8'd0, 8'd0, 32'd0);
      send_request(OP_NUMBER, 8'h00, 8'd0, 8'd0, 32'h8000_0000);
      settle();
      write_settings(1'b1, 32'd255, 32'd0, 32'd255, 32'd0);
      send_request(OP_SET_POS, 8'h00, 8'd1, 8'd80, 32'd0);
      send_request(OP_SET_POS, 8'h00, 8'd2, 8'd0, 32'd0);
      send_request(OP_SET_POS, 8'h00, 8'd4, 8'd1, 32'd0);
      settle();
   endtask

   task automatic test_random_traffic(int count, int sender_pct, int receiver_pct,
                                      bit pause_midway);
      int  start;
      bit  paused;
      write_settings(1'($urandom), $urandom, $urandom, $urandom, $urandom);
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      start  = requests_sent;
      paused = 1'b0;
      while (requests_sent - start < count) begin
         if (pause_midway && !paused && requests_sent - start >= count / 2) begin
            settle();
            paused = 1'b1;
         end
         send_random_request();
      end
      settle();
   endtask

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);

   always @(posedge clock) begin : check_results
      lcd_write_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bus_writes.size() == 0) begin
            $error("unexpected bus result: bus_value %0h", rsp_bus_value);
            failures++;
         end else begin
            want = bus_writes.pop_front();
            writes_checked++;
            if (rsp_register_select !== want.register_select) begin
               $error("register_select: expected %0d, got %0d",
                      want.register_select, rsp_register_select);
               failures++;
            end
            if (rsp_bus_value !== want.bus_value) begin
               $error("bus_value: expected %0h, got %0h", want.bus_value, rsp_bus_value);
               failures++;
            end
            if (rsp_write_strobe !== want.write_strobe) begin
               $error("write_strobe: expected %0d, got %0d",
                      want.write_strobe, rsp_write_strobe);
               failures++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** char_lcd_bus_write_engine_top: FAILED **");
         $finish;
      end
   end

   initial begin
      four_bit_mode = FOUR_BIT_RESET;
      row_base[1]   = ROW1_RESET;
      row_base[2]   = ROW2_RESET;
      row_base[3]   = ROW3_RESET;
      row_base[4]   = ROW4_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_requests();
      test_register_extremes();
      test_random_traffic(140, 26, 55, 1'b0);
      test_random_traffic(140, 55, 26, 1'b1);
      test_random_traffic(130, 0, 0, 1'b0);
      $display("Covered %0d requests and %0d ignored codes, %0d bus results checked,",
               requests_sent, ignored_sent, writes_checked);
      $display("over %0d register settings in both bus modes, with and without stalls.",
               settings_used);
      if (failures == 0)
         $display("** char_lcd_bus_write_engine_top: PASSED **");
      else
         $display("** char_lcd_bus_write_engine_top: FAILED **");
      $finish;
   end

endmodule
